// ----- rtl/bmq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmq_pkg: shared types and constants of the byte message queue
// Operation codes, configuration register indexes and the control word that
// is broadcast to every storage cell.
// ----------------------------------------------------------------------------
package bmq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_MAX_ITEM = 8;

    localparam int DATA_BYTES = 8;
    localparam int DATA_W     = 8 * DATA_BYTES;
    localparam int LANE_W     = 3;
    localparam int OFS_W      = 10;
    localparam int LEN_W      = 4;
    localparam int POS_W      = 6;
    localparam int OP_W       = 2;
    localparam int OUT_CNT_W  = 7;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int CAP_W      = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM     = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WR_BYTE = 2'd0,
        OP_WR_ITEM = 2'd1,
        OP_RD_BYTE = 2'd2,
        OP_RD_ITEM = 2'd3
    } t_op;

    typedef struct packed {
        logic              wr_en;
        logic              del_en;
        logic [OFS_W-1:0]  base;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] wdata;
    } t_cell_ctl;

endpackage

// ----- rtl/bmq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmq_cell: one byte of the message store
// Holds one byte, loads a byte of an appended item, takes the byte of a
// neighbor further back when bytes in front of it are removed, and places
// its byte on a read lane when it lies inside the read window.
// ----------------------------------------------------------------------------
module bmq_cell #(
    parameter int CELL_IDX = 0,
    parameter int MAX_ITEM = bmq_pkg::DEF_MAX_ITEM
) (
    input  logic                                    i_clk,
    input  bmq_pkg::t_cell_ctl                      i_ctl,
    input  logic [MAX_ITEM-1:0][7:0]                i_nbr,
    output logic [7:0]                              o_byte,
    output logic [bmq_pkg::DATA_BYTES-1:0][7:0]     o_rd
);

    localparam logic [bmq_pkg::OFS_W-1:0] IDX = bmq_pkg::OFS_W'(CELL_IDX);

    logic [7:0]                          r_byte;
    logic [7:0]                          n_byte;
    logic [bmq_pkg::OFS_W-1:0]           w_rel;
    logic [bmq_pkg::OFS_W-1:0]           w_end;
    logic [bmq_pkg::DATA_BYTES-1:0][7:0] w_wbytes;

    assign w_rel    = IDX - i_ctl.base;
    assign w_end    = i_ctl.base + bmq_pkg::OFS_W'(i_ctl.len);
    assign w_wbytes = i_ctl.wdata;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.wr_en && IDX >= i_ctl.base && IDX < w_end) begin
            n_byte = w_wbytes[w_rel[bmq_pkg::LANE_W-1:0]];
        end else if (i_ctl.del_en && IDX >= i_ctl.base) begin
            for (int k = 0; k < MAX_ITEM; k++) begin
                if (i_ctl.len == bmq_pkg::LEN_W'(k + 1)) begin
                    n_byte = i_nbr[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    always_comb begin
        o_rd = '0;
        for (int j = 0; j < MAX_ITEM; j++) begin
            if (IDX == i_ctl.base + bmq_pkg::OFS_W'(j) &&
                bmq_pkg::LEN_W'(j) < i_ctl.len) begin
                o_rd[j] = r_byte;
            end
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- rtl/byte_message_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_message_queue_core: packed byte store for message items
// A row of byte cells holds the queue packed from the front; appends, reads
// and deleting reads with compaction each take effect when accepted.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_axis channel carries one operation in s_axis_tuser
// (write byte, write item, read byte, read item) and its operands in
// s_axis_tdata. Every operation yields exactly one result transfer on
// m_axis with an ok flag, the read data, the byte count and the free space.
// The operation is carried out in the cycle it is accepted and its result
// is captured in the output register. One operation is taken per cycle unless
// the output stalls; a deleting read shifts all later cells toward the front
// in that same cycle, each cell taking the byte of the neighbor the deleted
// length behind it. When m_axis_tready is low the result waits in the output
// register and s_axis_tready drops until it is taken. Reset clears the byte
// count, sets the capacity to zero and the item size to one, and empties the
// output register. Configuration writes on the i_cfg port also empty the
// queue; the user must make them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module byte_message_queue_core #(
    parameter int CAPACITY = bmq_pkg::DEF_CAPACITY,
    parameter int MAX_ITEM = bmq_pkg::DEF_MAX_ITEM
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bmq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bmq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // write_data [63:0], position [69:64], delete_after [70], zero [71]
    input  logic [bmq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation [1:0]
    input  logic [bmq_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ok [0], read_data [64:1], byte_count [71:65], free_bytes [78:72],
    // zero [79]
    output logic [bmq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OFS_W = bmq_pkg::OFS_W;

    logic [bmq_pkg::CAP_W-1:0]          r_cap;
    logic [bmq_pkg::LEN_W-1:0]          r_isz;
    logic [CNT_W-1:0]                   r_held;
    logic                               r_out_valid;
    logic [bmq_pkg::OUT_TDATA_W-1:0]    r_out_data;

    logic                               w_accept;
    bmq_pkg::t_op                       w_op;
    logic [bmq_pkg::DATA_W-1:0]         w_wdata;
    logic [bmq_pkg::POS_W-1:0]          w_pos;
    logic                               w_del;
    logic [OFS_W-1:0]                   w_cap_eff;
    logic [OFS_W-1:0]                   w_held;
    logic [OFS_W-1:0]                   w_isz;
    logic [OFS_W-1:0]                   w_off;
    logic                               w_cfg_ok;
    logic                               w_ok;
    logic                               w_wr;
    logic                               w_rd;
    logic [OFS_W-1:0]                   w_base;
    logic [bmq_pkg::LEN_W-1:0]          w_len;
    logic [OFS_W-1:0]                   n_held;
    logic [OFS_W-1:0]                   w_free;
    logic [bmq_pkg::DATA_W-1:0]         w_rdata;
    bmq_pkg::t_cell_ctl                 w_ctl;

    logic [CAPACITY+MAX_ITEM-1:0][7:0]                 w_bytes;
    logic [CAPACITY-1:0][bmq_pkg::DATA_BYTES-1:0][7:0] w_rd_lanes;
    logic [bmq_pkg::DATA_BYTES-1:0][7:0]               w_rd_or;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_op    = bmq_pkg::t_op'(s_axis_tuser);
    assign w_wdata = s_axis_tdata[bmq_pkg::DATA_W-1:0];
    assign w_pos   = s_axis_tdata[bmq_pkg::DATA_W +: bmq_pkg::POS_W];
    assign w_del   = s_axis_tdata[bmq_pkg::DATA_W + bmq_pkg::POS_W];

    assign w_cap_eff = (OFS_W'(r_cap) > OFS_W'(CAPACITY)) ? OFS_W'(CAPACITY)
                                                          : OFS_W'(r_cap);
    assign w_held    = OFS_W'(r_held);
    assign w_isz     = OFS_W'(r_isz);
    assign w_off     = OFS_W'(w_pos) * w_isz;
    assign w_cfg_ok  = (w_cap_eff != '0) && (r_isz != '0) &&
                       (w_isz <= OFS_W'(MAX_ITEM));

    always_comb begin
        w_ok   = 1'b0;
        w_wr   = 1'b0;
        w_rd   = 1'b0;
        w_base = w_held;
        w_len  = r_isz;
        case (w_op)
            bmq_pkg::OP_WR_BYTE: begin
                w_ok   = w_cfg_ok && (r_isz == bmq_pkg::LEN_W'(1)) && (w_held < w_cap_eff);
                w_wr   = 1'b1;
                w_base = w_held;
                w_len  = bmq_pkg::LEN_W'(1);
            end
            bmq_pkg::OP_WR_ITEM: begin
                w_ok   = w_cfg_ok && (w_held + w_isz <= w_cap_eff);
                w_wr   = 1'b1;
                w_base = w_held;
                w_len  = r_isz;
            end
            bmq_pkg::OP_RD_BYTE: begin
                w_ok   = w_cfg_ok && (r_isz == bmq_pkg::LEN_W'(1)) &&
                         (OFS_W'(w_pos) < w_held);
                w_rd   = 1'b1;
                w_base = OFS_W'(w_pos);
                w_len  = bmq_pkg::LEN_W'(1);
            end
            bmq_pkg::OP_RD_ITEM: begin
                w_ok   = w_cfg_ok && (w_off + w_isz <= w_held);
                w_rd   = 1'b1;
                w_base = w_off;
                w_len  = r_isz;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_held = w_held;
        if (w_ok && w_wr) begin
            n_held = w_held + OFS_W'(w_len);
        end else if (w_ok && w_rd && w_del) begin
            n_held = w_held - OFS_W'(w_len);
        end
    end

    assign w_free = w_cap_eff - n_held;

    assign w_ctl.wr_en  = w_accept && w_ok && w_wr && !i_cfg_we;
    assign w_ctl.del_en = w_accept && w_ok && w_rd && w_del && !i_cfg_we;
    assign w_ctl.base   = w_base;
    assign w_ctl.len    = w_len;
    assign w_ctl.wdata  = w_wdata;

    assign w_bytes[CAPACITY+MAX_ITEM-1:CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bmq_cell #(
            .CELL_IDX (g),
            .MAX_ITEM (MAX_ITEM)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_nbr  (w_bytes[g+MAX_ITEM:g+1]),
            .o_byte (w_bytes[g]),
            .o_rd   (w_rd_lanes[g])
        );
    end

    always_comb begin
        w_rd_or = '0;
        for (int c = 0; c < CAPACITY; c++) begin
            w_rd_or = w_rd_or | w_rd_lanes[c];
        end
    end

    assign w_rdata = (w_ok && w_rd) ? w_rd_or : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_isz  <= bmq_pkg::LEN_W'(1);
            r_held <= '0;
        end else if (i_cfg_we) begin
            r_held <= '0;
            if (i_cfg_idx == bmq_pkg::CFG_CAPACITY) begin
                r_cap <= i_cfg_data[bmq_pkg::CAP_W-1:0];
            end else if (i_cfg_idx == bmq_pkg::CFG_ITEM) begin
                r_isz <= i_cfg_data[bmq_pkg::LEN_W-1:0];
            end
        end else if (w_accept) begin
            r_held <= n_held[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {1'b0,
                           w_free[bmq_pkg::OUT_CNT_W-1:0],
                           n_held[bmq_pkg::OUT_CNT_W-1:0],
                           w_rdata,
                           w_ok};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_held_within_capacity: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        OFS_W'(r_held) <= w_cap_eff
    ) else $error("byte count exceeds the effective capacity");

    a_reject_keeps_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_ok && !i_cfg_we) |=> $stable(r_held)
    ) else $error("rejected operation changed the byte count");

    a_reject_zero_data: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[bmq_pkg::DATA_W:1] == '0)
    ) else $error("rejected operation returned nonzero read data");

endmodule

// ----- tb/tb_byte_message_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_message_queue_core: self-checking bench for the byte message queue
// Drives byte and item appends and reads, with and without deletion, over a
// range of capacity and item size settings. It predicts every result in step
// with the accepted operations and compares ok, read data, count and free
// space of the output transfers in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_byte_message_queue_core;

    localparam int STORE_BYTES = bmq_pkg::DEF_CAPACITY;
    localparam int ITEM_MAX    = bmq_pkg::DEF_MAX_ITEM;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic                       ok;
        logic [bmq_pkg::DATA_W-1:0] rdata;
        logic [6:0]                 count;
        logic [6:0]                 free;
    } t_queue_result;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_we      = 1'b0;
    logic [bmq_pkg::CFG_IDX_W-1:0]      i_cfg_idx     = bmq_pkg::CFG_CAPACITY;
    logic [bmq_pkg::CFG_DATA_W-1:0]     i_cfg_data    = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [bmq_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic [bmq_pkg::OP_W-1:0]           s_axis_tuser  = bmq_pkg::OP_WR_BYTE;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [bmq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

    logic [7:0]      store_bytes [STORE_BYTES];
    int              held_bytes  = 0;
    int              queue_cap   = 0;
    int              item_len    = 1;
    t_queue_result   expected_results [$];
    int              error_count = 0;
    int              sent_items  = 0;
    int              quiet_cycles = 0;
    bit              idle_en     = 1'b1;

    byte_message_queue_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= !idle_en || ($urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_byte_message_queue_core: FAIL");
        $finish;
    end

    function automatic int usable_room();
        return (queue_cap > STORE_BYTES) ? STORE_BYTES : queue_cap;
    endfunction

    function automatic void drop_bytes(input int at, input int n);
        int i;
        for (i = at; i + n < held_bytes; i++) begin
            store_bytes[i] = store_bytes[i + n];
        end
        held_bytes -= n;
    endfunction

    function automatic t_queue_result apply_queue_op(input bmq_pkg::t_op op,
                                                     input logic [63:0] wdata,
                                                     input logic [5:0] pos,
                                                     input logic del);
        t_queue_result r;
        int            room;
        int            ofs;
        int            i;
        room = usable_room();
        r    = '0;
        if (room != 0 && item_len >= 1 && item_len <= ITEM_MAX) begin
            case (op)
                bmq_pkg::OP_WR_BYTE: begin
                    if (item_len == 1 && held_bytes < room) begin
                        store_bytes[held_bytes] = wdata[7:0];
                        held_bytes++;
                        r.ok = 1'b1;
                    end
                end
                bmq_pkg::OP_WR_ITEM: begin
                    if (held_bytes + item_len <= room) begin
                        for (i = 0; i < item_len; i++) begin
                            store_bytes[held_bytes + i] = wdata[8*i +: 8];
                        end
                        held_bytes += item_len;
                        r.ok = 1'b1;
                    end
                end
                bmq_pkg::OP_RD_BYTE: begin
                    if (item_len == 1 && int'(pos) < held_bytes) begin
                        r.rdata[7:0] = store_bytes[pos];
                        if (del) begin
                            drop_bytes(int'(pos), 1);
                        end
                        r.ok = 1'b1;
                    end
                end
                default: begin
                    ofs = int'(pos) * item_len;
                    if (ofs + item_len <= held_bytes) begin
                        for (i = 0; i < item_len; i++) begin
                            r.rdata[8*i +: 8] = store_bytes[ofs + i];
                        end
                        if (del) begin
                            drop_bytes(ofs, item_len);
                        end
                        r.ok = 1'b1;
                    end
                end
            endcase
        end
        r.count = 7'(held_bytes);
        r.free  = 7'(room - held_bytes);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 200) begin
            $display("%0t ns: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata[64:1], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[0] !== want.ok) begin
                    report_mismatch("ok", 64'(m_axis_tdata[0]), 64'(want.ok));
                end
                if (m_axis_tdata[64:1] !== want.rdata) begin
                    report_mismatch("read_data", m_axis_tdata[64:1], want.rdata);
                end
                if (m_axis_tdata[71:65] !== want.count) begin
                    report_mismatch("byte_count", 64'(m_axis_tdata[71:65]), 64'(want.count));
                end
                if (m_axis_tdata[78:72] !== want.free) begin
                    report_mismatch("free_bytes", 64'(m_axis_tdata[78:72]), 64'(want.free));
                end
            end
        end
    end

    task automatic send_op(input bmq_pkg::t_op op, input logic [63:0] wdata,
                           input logic [5:0] pos, input logic del);
        int gap;
        gap = (idle_en && $urandom_range(99) < 8) ? $urandom_range(1, 2) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, del, pos, wdata};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(apply_queue_op(op, wdata, pos, del));
        sent_items++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [bmq_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bmq_pkg::CFG_DATA_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bmq_pkg::CFG_CAPACITY) begin
            queue_cap = int'(value);
        end else begin
            item_len = int'(value[3:0]);
        end
        held_bytes = 0;
    endtask

    task automatic test_no_queue();
        send_op(bmq_pkg::OP_WR_BYTE, 64'h5A, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_ITEM, '1, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_RD_BYTE, '0, 6'd0, 1'b1);
        send_op(bmq_pkg::OP_RD_ITEM, '0, 6'd0, 1'b1);
    endtask

    task automatic test_byte_access();
        write_register(bmq_pkg::CFG_CAPACITY, 7'd3);
        send_op(bmq_pkg::OP_WR_BYTE, 64'h00, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_BYTE, 64'hFF, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_BYTE, 64'hFFFF_FFFF_FFFF_FFA5, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_BYTE, 64'h11, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_RD_BYTE, '0, 6'd2, 1'b0);
        send_op(bmq_pkg::OP_RD_BYTE, '0, 6'd3, 1'b1);
        send_op(bmq_pkg::OP_RD_BYTE, '0, 6'd0, 1'b1);
        send_op(bmq_pkg::OP_RD_BYTE, '0, 6'd63, 1'b0);
    endtask

    task automatic test_item_access();
        write_register(bmq_pkg::CFG_CAPACITY, 7'd100);
        write_register(bmq_pkg::CFG_ITEM, 7'd8);
        send_op(bmq_pkg::OP_WR_ITEM, '1, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_ITEM, 64'h0123_4567_89AB_CDEF, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_BYTE, 64'h77, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_RD_BYTE, '0, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_RD_ITEM, '0, 6'd63, 1'b1);
        send_op(bmq_pkg::OP_RD_ITEM, '0, 6'd0, 1'b1);
        send_op(bmq_pkg::OP_RD_ITEM, '0, 6'd0, 1'b0);
        write_register(bmq_pkg::CFG_CAPACITY, 7'd7);
        write_register(bmq_pkg::CFG_ITEM, 7'd3);
        send_op(bmq_pkg::OP_WR_ITEM, 64'hAB_CDEF, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_ITEM, 64'h12_3456, 6'd0, 1'b0);
        send_op(bmq_pkg::OP_WR_ITEM, 64'h98_7654, 6'd0, 1'b0);
    endtask

    task automatic test_bad_item_size();
        write_register(bmq_pkg::CFG_ITEM, 7'd0);
        send_op(bmq_pkg::OP_WR_ITEM, 64'h42, 6'd0, 1'b0);
        write_register(bmq_pkg::CFG_ITEM, 7'h79);
        send_op(bmq_pkg::OP_RD_ITEM, '0, 6'd0, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int           phase;
        int           phase_len;
        int           k;
        int           mode_left;
        bit           filling;
        int           items;
        bmq_pkg::t_op op;
        logic [5:0]   pos;
        phase = 0;
        while (sent_items < n_items) begin
            case (phase)
                0: begin
                    write_register(bmq_pkg::CFG_CAPACITY, 7'd64);
                    write_register(bmq_pkg::CFG_ITEM, 7'd1);
                end
                1: write_register(bmq_pkg::CFG_CAPACITY, 7'd1);
                2: begin
                    write_register(bmq_pkg::CFG_CAPACITY, 7'd127);
                    write_register(bmq_pkg::CFG_ITEM, 7'd8);
                end
                3: write_register(bmq_pkg::CFG_ITEM, 7'h7F);
                4: write_register(bmq_pkg::CFG_CAPACITY, 7'd0);
                default: begin
                    case ($urandom_range(0, 9))
                        0: write_register(bmq_pkg::CFG_CAPACITY, 7'd0);
                        1: write_register(bmq_pkg::CFG_CAPACITY, 7'($urandom_range(65, 127)));
                        2: write_register(bmq_pkg::CFG_CAPACITY, 7'd64);
                        default: write_register(bmq_pkg::CFG_CAPACITY,
                                                7'($urandom_range(1, 64)));
                    endcase
                    case ($urandom_range(0, 19))
                        0: write_register(bmq_pkg::CFG_ITEM, 7'd0);
                        1: write_register(bmq_pkg::CFG_ITEM, 7'($urandom_range(9, 15)));
                        2, 3, 4, 5, 6, 7, 8, 9: begin
                            write_register(bmq_pkg::CFG_ITEM,
                                           {3'($urandom_range(0, 7)), 4'd1});
                        end
                        default: write_register(bmq_pkg::CFG_ITEM, 7'($urandom_range(2, 8)));
                    endcase
                end
            endcase
            idle_en = (phase != 0);
            if (phase == 0) begin
                phase_len = 300;
            end else if (usable_room() == 0 || item_len == 0 || item_len > ITEM_MAX) begin
                phase_len = 10;
            end else begin
                phase_len = $urandom_range(40, 160);
            end
            filling   = 1'b1;
            mode_left = $urandom_range(10, 70);
            for (k = 0; k < phase_len; k++) begin
                if (mode_left == 0) begin
                    filling   = !filling;
                    mode_left = $urandom_range(10, 70);
                end
                mode_left--;
                pos = 6'($urandom_range(0, 63));
                if ($urandom_range(99) < 8) begin
                    op = bmq_pkg::t_op'($urandom_range(0, 3));
                end else if ($urandom_range(99) < (filling ? 80 : 20)) begin
                    op = (item_len == 1 && $urandom_range(0, 1)) ? bmq_pkg::OP_WR_BYTE
                                                                  : bmq_pkg::OP_WR_ITEM;
                end else begin
                    op = (item_len == 1 && $urandom_range(0, 1)) ? bmq_pkg::OP_RD_BYTE
                                                                  : bmq_pkg::OP_RD_ITEM;
                    items = (item_len >= 1 && item_len <= ITEM_MAX) ?
                            held_bytes / item_len : 0;
                    if (op == bmq_pkg::OP_RD_BYTE && held_bytes > 0 &&
                        $urandom_range(99) < 90) begin
                        pos = 6'($urandom_range(0, held_bytes - 1));
                    end else if (op == bmq_pkg::OP_RD_ITEM && items > 0 &&
                                 $urandom_range(99) < 90) begin
                        pos = 6'($urandom_range(0, items - 1));
                    end
                end
                send_op(op, {$urandom, $urandom}, pos, 1'($urandom_range(0, 1)));
            end
            phase++;
        end
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_no_queue();
        test_byte_access();
        test_item_access();
        test_bad_item_size();
        test_random_traffic(1300);
        drain_results();
        repeat (2) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_byte_message_queue_core: PASS");
        end else begin
            $display("tb_byte_message_queue_core: FAIL");
        end
        $finish;
    end

endmodule
